// ----- hw/rtl/ptc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Payload structs, coefficient bundle, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package ptc_pkg;

	// input sample pair
	typedef struct packed {
		logic [9:0] pressure_count;
		logic [9:0] temperature_count;
	} sample_t;

	// compensated result
	typedef struct packed {
		logic [10:0]        pressure_sixteenths_kpa;
		logic               pressure_clipped;
		logic signed [11:0] temperature_sixteenths_c;
	} result_t;

	// coefficient words as held in the register file
	typedef struct packed {
		logic [15:0]        a0_word;
		logic [12:0]        b1_word;
		logic signed [15:0] b2_word;
		logic [15:0]        c12_word;
	} coef_t;

	// register indexes
	typedef enum logic [1:0] {
		CFG_A0  = 2'd0,
		CFG_B1  = 2'd1,
		CFG_B2  = 2'd2,
		CFG_C12 = 2'd3
	} cfg_reg_t;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;

	// B1 offset of three in Q24
	localparam logic signed [26:0] B1Offset = 27'sd50331648;

	// pressure: q = floor(y / 1023) = ((y + 1) * PresRecip) >> 30
	localparam logic [20:0] PresRecip = 21'd1049601;
	// first y whose quotient exceeds the top of range (1041 * 1023)
	localparam logic [25:0] PresHighY = 26'd1064943;
	localparam logic [10:0] PresMin   = 11'd800;
	localparam logic [10:0] PresMax   = 11'd1840;

	// temperature: floor((327376 - 320 t) / 107) - 1168
	localparam logic [18:0] TempNumBase = 19'd327376;
	localparam logic [20:0] TempRecip   = 21'd1254372;
	localparam logic [11:0] TempBias    = 12'd1168;

endpackage

// ----- hw/rtl/ptc_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_stream_if: valid/ready stream channel
// Carries one payload word; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ptc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (
		output valid,
		output payload,
		input  ready
	);

	modport sink (
		input  valid,
		input  payload,
		output ready
	);
endinterface

// ----- hw/rtl/ptc_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pipe: six-stage compensation datapath
// Polynomial evaluation, scaling to 1/16 kPa with saturation, and the
// temperature conversion, with per-stage valid bits and a ready chain.
// ----------------------------------------------------------------------------
module ptc_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptc_pkg::coef_t        coef,
	ptc_stream_if.sink            sample,
	ptc_stream_if.source          result
);

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	// stage 1: coefficient products with T, temperature numerator
	logic [9:0]         p_s1;
	logic [25:0]        c12t_s1;
	logic signed [25:0] b2t_s1;
	logic [18:0]        tn_s1;

	// stage 2: (B1 + C12*T)*P, temperature quotient
	logic signed [36:0] bp_s2;
	logic signed [25:0] b2t_s2;
	logic [11:0]        tq_s2;

	// stage 3: Pcomp in Q24
	logic signed [39:0] pcomp_s3;
	logic [11:0]        temp_s3;

	// stage 4: scaled value and range flags
	logic [20:0] yp1_s4;
	logic        lo_s4, hi_s4;
	logic [11:0] temp_s4;

	// stage 5: quotient
	logic [10:0] q_s5;
	logic        lo_s5, hi_s5;
	logic [11:0] temp_s5;

	// stage 6: result register
	ptc_pkg::result_t res_s6;

	// combinational terms
	logic signed [25:0] b2_ext, t_ext;
	logic [9:0]         p_in, t_in;
	logic signed [26:0] b1_val, sum_bc;
	logic [39:0]        tprod;
	logic signed [46:0] px, x65;
	logic signed [26:0] y;
	logic [41:0]        qprod;

	// ready chain: a stage moves when it is empty or the next one moves
	assign en6 = !v_s6 || result.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign sample.ready   = en1;
	assign result.valid   = v_s6;
	assign result.payload = res_s6;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1 terms
	assign p_in   = sample.payload.pressure_count;
	assign t_in   = sample.payload.temperature_count;
	assign b2_ext = 26'(coef.b2_word);
	assign t_ext  = $signed({16'b0, t_in});

	always_ff @(posedge clk) begin
		if (en1) begin
			p_s1    <= p_in;
			c12t_s1 <= 26'(coef.c12_word) * 26'(t_in);
			b2t_s1  <= b2_ext * t_ext;
			tn_s1   <= ptc_pkg::TempNumBase - (19'(t_in) << 8) - (19'(t_in) << 6);
		end
	end

	// stage 2 terms
	assign b1_val = $signed({3'b0, coef.b1_word, 11'b0}) - ptc_pkg::B1Offset;
	assign sum_bc = b1_val + $signed({1'b0, c12t_s1});
	assign tprod  = 40'(tn_s1) * 40'(ptc_pkg::TempRecip);

	always_ff @(posedge clk) begin
		if (en2) begin
			bp_s2  <= 37'(sum_bc) * $signed({27'b0, p_s1});
			b2t_s2 <= b2t_s1;
			tq_s2  <= tprod[38:27];
		end
	end

	// stage 3: sum of the three polynomial terms
	always_ff @(posedge clk) begin
		if (en3) begin
			pcomp_s3 <= $signed({3'b0, coef.a0_word, 21'b0})
				+ 40'(bp_s2)
				+ $signed({{4{b2t_s2[25]}}, b2t_s2, 10'b0});
			temp_s3  <= tq_s2 - ptc_pkg::TempBias;
		end
	end

	// stage 4: y = floor(Pcomp * 65 / 2^20), then range check against 1023 steps
	assign px  = 47'(pcomp_s3);
	assign x65 = (px <<< 6) + px;
	assign y   = x65[46:20];

	always_ff @(posedge clk) begin
		if (en4) begin
			lo_s4   <= y[26];
			hi_s4   <= !y[26] && (y[25:0] >= ptc_pkg::PresHighY);
			yp1_s4  <= y[20:0] + 21'd1;
			temp_s4 <= temp_s3;
		end
	end

	// stage 5: divide by 1023 through the reciprocal
	assign qprod = 42'(yp1_s4) * 42'(ptc_pkg::PresRecip);

	always_ff @(posedge clk) begin
		if (en5) begin
			q_s5    <= qprod[40:30];
			lo_s5   <= lo_s4;
			hi_s5   <= hi_s4;
			temp_s5 <= temp_s4;
		end
	end

	// stage 6: offset and saturation
	always_ff @(posedge clk) begin
		if (en6) begin
			if (lo_s5) begin
				res_s6.pressure_sixteenths_kpa <= ptc_pkg::PresMin;
			end else if (hi_s5) begin
				res_s6.pressure_sixteenths_kpa <= ptc_pkg::PresMax;
			end else begin
				res_s6.pressure_sixteenths_kpa <= q_s5 + ptc_pkg::PresMin;
			end
			res_s6.pressure_clipped         <= lo_s5 || hi_s5;
			res_s6.temperature_sixteenths_c <= $signed(temp_s5);
		end
	end

endmodule

// ----- hw/rtl/pressure_temperature_compensation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: barometric pressure compensation
// Coefficient registers and a pipelined polynomial datapath that turns a
// pressure/temperature count pair into kPa and degrees C in 1/16 units.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// sample    in         valid / ready      pressure_count, temperature_count
// result    out        valid / ready      pressure_sixteenths_kpa,
//                                         pressure_clipped,
//                                         temperature_sixteenths_c
// config    in         cfg_we             cfg_index, cfg_data
//
// one pair per cycle unless the result is stalled and every stage is full;
// each pair passes through the six register stages of the datapath
// reset clears the valid bits and the coefficient words to zero
// a stalled result holds stage six; earlier stages keep filling bubbles
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ptc_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [ptc_pkg::CfgDataW-1:0]    cfg_data,
	ptc_stream_if.sink                      sample,
	ptc_stream_if.source                    result
);

	ptc_pkg::coef_t coef_q;

	// coefficient register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (ptc_pkg::cfg_reg_t'(cfg_index))
				ptc_pkg::CFG_A0:  coef_q.a0_word  <= cfg_data;
				ptc_pkg::CFG_B1:  coef_q.b1_word  <= cfg_data[12:0];
				ptc_pkg::CFG_B2:  coef_q.b2_word  <= $signed(cfg_data);
				ptc_pkg::CFG_C12: coef_q.c12_word <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath
	ptc_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef_q),
		.sample (sample),
		.result (result)
	);

`ifndef SYNTHESIS
	// input only stalls when every stage is full and the output is blocked
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (result.valid && !result.ready))
		else $error("input stalled while pipeline has room");

	// pressure always within saturation bounds
	a_pres_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.payload.pressure_sixteenths_kpa >= ptc_pkg::PresMin
			&& result.payload.pressure_sixteenths_kpa <= ptc_pkg::PresMax))
		else $error("pressure out of range");

	// clip flag only with a boundary value
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.pressure_clipped) |->
			(result.payload.pressure_sixteenths_kpa == ptc_pkg::PresMin
			|| result.payload.pressure_sixteenths_kpa == ptc_pkg::PresMax))
		else $error("clip flag with non-boundary pressure");

	// temperature within the span of a 10-bit count
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.payload.temperature_sixteenths_c >= -12'sd1168
			&& result.payload.temperature_sixteenths_c <= 12'sd1891))
		else $error("temperature out of range");
`endif

endmodule
